// ===== rtl/erle_pkg.sv =====
// Shared types and constants for the escape-coded run-length byte encoder.
// Used by every module of the block; depends on nothing.
package erle_pkg;

    // Byte and count widths
    localparam int BYTE_W    = 8;
    localparam int RUN_W     = 7;
    localparam int MAX_BYTES = 7;
    localparam int IDX_W     = 3;

    // Configuration register indexes
    localparam logic REG_ESCAPE  = 1'b0;
    localparam logic REG_MAX_RUN = 1'b1;

    // Register reset values
    localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'hFE;
    localparam logic [RUN_W-1:0]  MAX_RUN_RESET = 7'd127;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 2;

    // One command: the output bytes caused by one input byte
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 cnt;
        logic                             term;
    } cmd_t;

endpackage

// ===== rtl/erle_front.sv =====
// Front end: accepts raw bytes, keeps run state and builds one output command.
// Depends on erle_pkg.
module erle_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [erle_pkg::BYTE_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic [erle_pkg::BYTE_W-1:0] in_byte,
    input  logic                        is_last,
    input  logic                        queue_full,
    output logic                        in_stall,
    output logic                        push,
    output erle_pkg::cmd_t              cmd
);

    logic [erle_pkg::BYTE_W-1:0] escape_reg;
    logic [erle_pkg::RUN_W-1:0]  max_run_reg;
    logic [erle_pkg::BYTE_W-1:0] prev_reg, prev_next;
    logic [erle_pkg::RUN_W-1:0]  run_len_reg, run_len_next;
    logic                        run_open_reg, run_open_next;
    logic                        hdr_sent_reg, hdr_sent_next;
    logic [erle_pkg::RUN_W-1:0]  limit;
    logic                        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign limit    = (max_run_reg == '0) ? erle_pkg::RUN_W'(1) : max_run_reg;

    // Classify the byte and list its output bytes in order
    always_comb
    begin
        logic [erle_pkg::IDX_W-1:0] k;
        k             = '0;
        cmd           = '0;
        prev_next     = prev_reg;
        run_len_next  = run_len_reg;
        run_open_next = run_open_reg;
        hdr_sent_next = hdr_sent_reg;

        if (!hdr_sent_next)
        begin
            cmd.bytes[k]  = escape_reg;
            k             = k + 3'd1;
            prev_next     = escape_reg;
            hdr_sent_next = 1'b1;
            run_open_next = 1'b0;
            run_len_next  = '0;
        end

        if (run_open_next && in_byte == prev_next)
        begin
            run_len_next = run_len_next + 7'd1;
        end
        else
        begin
            if (run_open_next)
            begin
                cmd.bytes[k]  = escape_reg;
                k             = k + 3'd1;
                cmd.bytes[k]  = {1'b0, run_len_next};
                k             = k + 3'd1;
                prev_next     = {1'b0, run_len_next};
                run_open_next = 1'b0;
                run_len_next  = '0;
            end
            priority if (in_byte == escape_reg)
            begin
                cmd.bytes[k] = escape_reg;
                k            = k + 3'd1;
                cmd.bytes[k] = escape_reg;
                k            = k + 3'd1;
                prev_next    = escape_reg;
            end
            else if (in_byte == prev_next)
            begin
                run_open_next = 1'b1;
                run_len_next  = 7'd1;
            end
            else
            begin
                cmd.bytes[k] = in_byte;
                k            = k + 3'd1;
                prev_next    = in_byte;
            end
        end

        // Close a run that reached its limit
        if (run_open_next && run_len_next >= limit)
        begin
            cmd.bytes[k]  = escape_reg;
            k             = k + 3'd1;
            cmd.bytes[k]  = {1'b0, run_len_next};
            k             = k + 3'd1;
            prev_next     = {1'b0, run_len_next};
            run_open_next = 1'b0;
            run_len_next  = '0;
        end

        // End of stream: close any run, then send the terminator
        if (is_last)
        begin
            if (run_open_next)
            begin
                cmd.bytes[k]  = escape_reg;
                k             = k + 3'd1;
                cmd.bytes[k]  = {1'b0, run_len_next};
                k             = k + 3'd1;
                run_open_next = 1'b0;
                run_len_next  = '0;
            end
            cmd.bytes[k]  = escape_reg;
            k             = k + 3'd1;
            cmd.bytes[k]  = '0;
            k             = k + 3'd1;
            cmd.term      = 1'b1;
            prev_next     = '0;
            hdr_sent_next = 1'b0;
        end

        cmd.cnt = k;
    end

    assign push = accept && (cmd.cnt != '0);

    // Hold configuration and advance run state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg   <= erle_pkg::ESCAPE_RESET;
            max_run_reg  <= erle_pkg::MAX_RUN_RESET;
            prev_reg     <= '0;
            run_len_reg  <= '0;
            run_open_reg <= 1'b0;
            hdr_sent_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    erle_pkg::REG_ESCAPE:  escape_reg  <= cfg_data;
                    erle_pkg::REG_MAX_RUN: max_run_reg <= cfg_data[erle_pkg::RUN_W-1:0];
                    default:               escape_reg  <= escape_reg;
                endcase
            end
            if (accept)
            begin
                prev_reg     <= prev_next;
                run_len_reg  <= run_len_next;
                run_open_reg <= run_open_next;
                hdr_sent_reg <= hdr_sent_next;
            end
        end
    end

endmodule

// ===== rtl/erle_cmd_fifo.sv =====
// Short command queue between the front end and the byte emitter.
// Depends on erle_pkg for the command type.
module erle_cmd_fifo
#(
    parameter int DEPTH = erle_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  erle_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output erle_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    erle_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("command queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty command queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("fill count missed a push");

endmodule

// ===== rtl/erle_emit.sv =====
// Back end: takes commands from the queue and sends their bytes one a beat.
// Depends on erle_pkg for the command type.
module erle_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        queue_empty,
    input  erle_pkg::cmd_t              head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [erle_pkg::BYTE_W-1:0] out_byte,
    output logic                        last_of_step,
    output logic                        stream_end
);

    erle_pkg::cmd_t             cur_reg;
    logic [erle_pkg::IDX_W-1:0] idx_reg;
    logic                       busy_reg;
    logic                       final_beat;
    logic                       done;

    assign out_valid    = busy_reg;
    assign out_byte     = cur_reg.bytes[idx_reg];
    assign final_beat   = (idx_reg == cur_reg.cnt - 3'd1);
    assign last_of_step = final_beat;
    assign stream_end   = cur_reg.term && final_beat;
    assign done         = busy_reg && !out_stall && final_beat;
    assign pop          = !queue_empty && (!busy_reg || done);

    // Load the next command or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            priority if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else if (busy_reg && !out_stall)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // Hold the command payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cur_reg.cnt != '0)
        else $error("empty command loaded");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> idx_reg < cur_reg.cnt)
        else $error("byte index past command length");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_stall) |=> busy_reg && $stable(idx_reg))
        else $error("stalled beat moved");

endmodule

// ===== rtl/escape_rle_byte_encoder_unit.sv =====
// Escape-coded run-length byte encoder, top level. The first output byte of an
// item passes through the command queue and the emitter's command register.
// Throughput: one input byte per cycle while the command queue has room; the
// emitter sends one output byte per cycle while out_stall is low.
// Reset: run state and header flag clear, escape_code = 254, max_run = 127.
// Depends on erle_pkg, erle_front, erle_cmd_fifo and erle_emit.
module escape_rle_byte_encoder_unit
#(
    parameter int QUEUE_DEPTH = erle_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [erle_pkg::BYTE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [erle_pkg::BYTE_W-1:0] in_byte,
    input  logic                        is_last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [erle_pkg::BYTE_W-1:0] out_byte,
    output logic                        last_of_step,
    output logic                        stream_end
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    erle_pkg::cmd_t push_cmd;
    erle_pkg::cmd_t head_cmd;

    // Classify input bytes
    erle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Buffer commands
    erle_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head_cmd)
    );

    // Send output bytes
    erle_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_step (last_of_step),
        .stream_end   (stream_end)
    );

endmodule
